>>> rtl/lkv_pkg.sv
// lkv_pkg: shared constants, codes and the wave record handed between cache cells.
// No dependencies; used by every module of the LRU key-value cache.
`timescale 1ns / 1ps
package lkv_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_WRITE  = 1'b1;

  // register index, taken from the word part of paddr
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic             valid;
    logic             done;
    logic             evict;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } wave_t;

endpackage

>>> rtl/lru_key_value_cache_unit.sv
// LRU key-value cache: the recency chain of lkv_cell entries plus request control.
// Depends on lkv_pkg and lkv_cell.
//
// Usage: requests enter on the s_ stream (s_tuser = action, 0 lookup / 1 write;
// s_tdata = lookup_key then write_value). One result per request leaves on the
// m_ stream (m_tuser = found, m_tdata = read_value). The APB port holds the
// capacity register at address 0 (values 0 and above ENTRIES are clamped).
// Entries are kept most recent first along a chain of cells. A request first
// enters a compare state in which every cell checks its key at once; a lookup
// miss then finishes. Any other request launches a wave that walks the chain
// one cell per cycle, shifting entries down until it reaches the hit, a free
// cell or the victim, and waits in the sweep state until the wave leaves the
// end of the chain. One request is in work at a time, so no new request is
// taken before the last one is finished; the sweep time is set by the chain length.
// s_tready is high only while no request is in work; a finished result sits in
// the output register while the next request is taken. If m_tready stays low,
// the next result waits in its last stage until the register frees up.
// Reset empties the store, sets capacity to 16 and drops any pending beat.
`timescale 1ns / 1ps
module lru_key_value_cache_unit #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [63:0]                s_tdata,   // [31:0] lookup_key, [63:32] write_value
  input  logic                       s_tuser,   // [0] action
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [31:0]                m_tdata,   // [31:0] read_value
  output logic                       m_tuser,   // [0] found
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lkv_pkg::ADDR_W-1:0] paddr,
  input  logic [lkv_pkg::DATA_W-1:0] pwdata,
  output logic [lkv_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import lkv_pkg::*;

  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNTW = $clog2(ENTRIES + 1);
  localparam int WW   = (CNTW > CAP_W) ? CNTW : CAP_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]       state;
  logic             req_act;
  logic [KEY_W-1:0] req_key;
  logic [VAL_W-1:0] req_val;
  logic             res_found;
  logic [VAL_W-1:0] res_value;
  logic [CNTW-1:0]  count;
  logic [CAP_W-1:0] capacity;

  wave_t            chain [ENTRIES+1];
  logic [ENTRIES-1:0] match_vec;
  logic [VAL_W-1:0] cell_value [ENTRIES];

  logic             found;
  logic [VAL_W-1:0] hit_value;
  logic [WW-1:0]    cap_eff;
  logic             full;
  logic             evict;
  logic [IW-1:0]    victim;
  logic             load_out;

  // chain of cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkv_cell #(.ENTRIES(ENTRIES), .INDEX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wave_in  (chain[i]),
      .wave_out (chain[i+1]),
      .req_key  (req_key),
      .victim   (victim),
      .match    (match_vec[i]),
      .value    (cell_value[i])
    );
  end

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_value = hit_value | (cell_value[i] & {VAL_W{match_vec[i]}});
    end
  end

  assign found = |match_vec;

  always_comb begin
    priority if (capacity == '0) begin
      cap_eff = WW'(1);
    end else if (WW'(capacity) > WW'(ENTRIES)) begin
      cap_eff = WW'(ENTRIES);
    end else begin
      cap_eff = WW'(capacity);
    end
  end

  assign full   = WW'(count) >= cap_eff;
  assign evict  = (req_act == ACT_WRITE) && !found && full;
  assign victim = IW'(count - CNTW'(1));

  always_comb begin
    chain[0].valid = (state == ST_CMP) && ((req_act == ACT_WRITE) || found);
    chain[0].done  = 1'b0;
    chain[0].evict = evict;
    chain[0].key   = req_key;
    chain[0].value = (req_act == ACT_WRITE) ? req_val : hit_value;
  end

  assign s_tready = (state == ST_IDLE);
  assign load_out = (state == ST_FIN) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_CMP;
        end
        ST_CMP: begin
          if ((req_act == ACT_WRITE) && !found && !full) count <= count + CNTW'(1);
          state <= ((req_act == ACT_WRITE) || found) ? ST_SWEEP : ST_FIN;
        end
        ST_SWEEP: begin
          if (chain[ENTRIES].valid) state <= ST_FIN;
        end
        ST_FIN: begin
          if (load_out) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_act <= s_tuser;
      req_key <= s_tdata[KEY_W-1:0];
      req_val <= s_tdata[KEY_W+VAL_W-1:KEY_W];
    end
    if (state == ST_CMP) begin
      res_found <= found;
      if (req_act == ACT_WRITE) begin
        res_value <= '0;
      end else begin
        res_value <= found ? hit_value : '1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tuser <= res_found;
      m_tdata <= res_value;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(capacity) : '0;

endmodule

>>> rtl/lkv_cell.sv
// lkv_cell: one entry of the recency-ordered chain (key, value, valid).
// Depends on lkv_pkg. A passing wave shifts the entry one place down until it stops.
`timescale 1ns / 1ps
module lkv_cell #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF,
  parameter int INDEX   = 0,
  localparam int IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lkv_pkg::wave_t           wave_in,
  output lkv_pkg::wave_t           wave_out,
  input  logic [lkv_pkg::KEY_W-1:0] req_key,
  input  logic [IW-1:0]            victim,
  output logic                     match,
  output logic [lkv_pkg::VAL_W-1:0] value
);
  import lkv_pkg::*;

  logic             valid;
  logic [KEY_W-1:0] key;
  logic             stop;
  logic             take;

  assign match = valid && (key == req_key);
  assign stop  = !valid || (key == req_key) || (wave_in.evict && (victim == IW'(INDEX)));
  assign take  = wave_in.valid && !wave_in.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid          <= 1'b0;
      wave_out.valid <= 1'b0;
      wave_out.done  <= 1'b0;
      wave_out.evict <= 1'b0;
    end else begin
      wave_out.valid <= wave_in.valid;
      wave_out.evict <= wave_in.evict;
      if (take) begin
        valid         <= 1'b1;
        wave_out.done <= stop;
      end else begin
        wave_out.done <= wave_in.done;
      end
    end
    if (take) begin
      key            <= wave_in.key;
      value          <= wave_in.value;
      wave_out.key   <= key;
      wave_out.value <= value;
    end
  end

endmodule

>>> rtl/lkv_checker.sv
// lkv_checker: port-level assertions for lru_key_value_cache_unit, bound to the top.
// Depends on lkv_pkg for port widths.
`timescale 1ns / 1ps
module lkv_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic [63:0]                s_tdata,
  input logic                       s_tuser,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [31:0]                m_tdata,
  input logic                       m_tuser,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [lkv_pkg::ADDR_W-1:0] paddr,
  input logic [lkv_pkg::DATA_W-1:0] pwdata,
  input logic [lkv_pkg::DATA_W-1:0] prdata,
  input logic                       pready
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again right after an accept");

  // a fresh result is loaded only from the finishing stage, never while idle
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without a request in work");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("reset did not empty the block");

endmodule

bind lru_key_value_cache_unit lkv_checker u_lkv_checker (.*);

>>> test/tb.sv
// tb: self-checking bench for lru_key_value_cache_unit; a scoreboard class keeps its own LRU model.
// Depends on lkv_pkg and the cache RTL; drives requests, random stalls and capacity writes over APB.
`timescale 1ns / 1ps
module tb;
  import lkv_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  class lru_scoreboard;
    localparam int SLOTS = lkv_pkg::ENTRIES_DEF;

    typedef struct {
      logic        found;
      logic [31:0] value;
    } reply_t;

    logic [31:0] slot_key [SLOTS];
    logic [31:0] slot_val [SLOTS];
    bit          slot_used[SLOTS];
    int unsigned slot_age [SLOTS];
    int unsigned fill;
    logic [4:0]  cap_reg;
    reply_t      expected_replies[$];
    int          errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        slot_key[i]  = '0;
        slot_val[i]  = '0;
        slot_used[i] = 1'b0;
        slot_age[i]  = 0;
      end
      fill    = 0;
      cap_reg = CAP_RESET;
      errors  = 0;
    endfunction

    function void set_capacity(logic [4:0] v);
      cap_reg = v;
    endfunction

    function int unsigned usable_slots();
      int unsigned c;
      c = cap_reg;
      if (c == 0) c = 1;
      if (c > SLOTS) c = SLOTS;
      return c;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // move slot s to the front; entries that were newer age by one
    function void promote(int s);
      int unsigned r;
      r = slot_age[s];
      for (int i = 0; i < SLOTS; i++)
        if (slot_used[i] && slot_age[i] < r) slot_age[i]++;
      slot_age[s] = 0;
    endfunction

    function void apply_request(logic act, logic [31:0] key, logic [31:0] val);
      int          hit;
      int          slot;
      int unsigned oldest;
      reply_t      r;
      hit = -1;
      for (int i = 0; i < SLOTS; i++)
        if (hit < 0 && slot_used[i] && slot_key[i] == key) hit = i;
      if (act == ACT_LOOKUP) begin
        if (hit >= 0) begin
          promote(hit);
          r.found = 1'b1;
          r.value = slot_val[hit];
        end else begin
          r.found = 1'b0;
          r.value = '1;
        end
      end else if (hit >= 0) begin
        slot_val[hit] = val;
        promote(hit);
        r.found = 1'b1;
        r.value = '0;
      end else begin
        slot = -1;
        oldest = 0;
        if (fill >= usable_slots()) begin
          for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && (slot < 0 || slot_age[i] > oldest)) begin
              slot = i;
              oldest = slot_age[i];
            end
          if (slot >= 0) begin
            slot_used[slot] = 1'b0;
            fill--;
          end
        end
        if (slot < 0)
          for (int i = SLOTS - 1; i >= 0; i--)
            if (!slot_used[i]) slot = i;
        if (slot >= 0) begin
          for (int i = 0; i < SLOTS; i++)
            if (slot_used[i]) slot_age[i]++;
          slot_key[slot]  = key;
          slot_val[slot]  = val;
          slot_used[slot] = 1'b1;
          slot_age[slot]  = 0;
          fill++;
        end
        r.found = 1'b0;
        r.value = '0;
      end
      expected_replies.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_reply(logic found, logic [31:0] value);
      reply_t r;
      if (expected_replies.size() == 0) begin
        report($sformatf("unexpected beat found=%0b value=%h", found, value));
      end else begin
        r = expected_replies.pop_front();
        if (found !== r.found)
          report($sformatf("found %0b, expected %0b", found, r.found));
        if (value !== r.value)
          report($sformatf("read_value %h, expected %h", value, r.value));
      end
    endtask
  endclass

  logic              clk;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [63:0]       s_tdata = '0;   // [31:0] lookup_key, [63:32] write_value
  logic              s_tuser = 1'b0; // [0] action
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [31:0]       m_tdata;        // [31:0] read_value
  logic              m_tuser;        // [0] found
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lru_scoreboard sb = new();
  int            src_idle = 0;
  int            sink_stall = 0;
  int            cycles = 0;
  logic [31:0]   key_pool[24];

  lru_key_value_cache_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_reply(m_tuser, m_tdata);
    m_tready <= ($urandom_range(99) >= sink_stall);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task send_request(logic act, logic [31:0] key, logic [31:0] val);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {val, key};
    do @(posedge clk); while (!s_tready);
    sb.apply_request(act, key, val);
  endtask

  task drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task write_capacity(logic [4:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= {27'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_capacity(v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [31:0] pick_key(int window);
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(window - 1)];
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(19))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task run_phase(logic [4:0] cap, int src, int sink, int n, int window);
    drain();
    write_capacity(cap);
    src_idle   = src;
    sink_stall = sink;
    for (int i = 0; i < n; i++)
      send_request($urandom_range(1) ? ACT_WRITE : ACT_LOOKUP, pick_key(window), pick_value());
  endtask

  initial begin
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 24; i++) key_pool[i] = $urandom;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store, key and value extremes, hits of both kinds, then fill past capacity
    send_request(ACT_LOOKUP, 32'h8000_0000, 32'h1234_5678);
    send_request(ACT_WRITE,  32'h8000_0000, 32'h7FFF_FFFF);
    send_request(ACT_LOOKUP, 32'h8000_0000, 32'h0);
    send_request(ACT_WRITE,  32'h7FFF_FFFF, 32'h8000_0000);
    send_request(ACT_WRITE,  32'h0000_0000, 32'hFFFF_FFFF);
    send_request(ACT_WRITE,  32'hFFFF_FFFF, 32'h0000_0000);
    send_request(ACT_WRITE,  32'h8000_0000, 32'hFFFF_FFFF);
    send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_LOOKUP, 32'h0000_0000, 32'h0);
    send_request(ACT_LOOKUP, 32'h1234_5678, 32'h0);
    send_request(ACT_LOOKUP, 32'h7FFF_FFFF, 32'h0);
    for (int i = 0; i < 13; i++)
      send_request(ACT_WRITE, 32'h100 + i, i);

    run_phase(5'd16, 0,  0,  90, 20);
    run_phase(5'd1,  56, 0,  60, 4);
    run_phase(5'd0,  0,  56, 50, 4);
    run_phase(5'd31, 26, 26, 90, 24);
    run_phase(5'd4,  0,  0,  70, 10);   // lowered below the fill
    run_phase(5'd16, 56, 0,  60, 20);
    run_phase(5'd8,  0,  56, 60, 12);
    run_phase(5'd17, 26, 26, 50, 22);

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/lkv_pkg.sv
rtl/lkv_cell.sv
rtl/lru_key_value_cache_unit.sv
rtl/lkv_checker.sv
test/tb.sv
